[rtl/tpwd_pkg.sv]
package tpwd_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int COUNT_WIDTH  = 16;

    localparam int THR_WIDTH   = 15;
    localparam int LIMIT_WIDTH = 16;
    localparam int BYTE_WIDTH  = 8;

    localparam int S_TDATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH = 8;

    localparam int LVL_WIDTH = ((SAMPLE_WIDTH > THR_WIDTH + 1) ? SAMPLE_WIDTH : THR_WIDTH + 1) + 1;
    localparam int CMP_WIDTH = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int CFG_IDX_WIDTH = 2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_LEVEL_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SHORT_LIMIT     = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_LONG_LIMIT      = 2'd2;

    localparam logic [BYTE_WIDTH-1:0] SYNC_BYTE = 8'hA5;

    localparam logic [THR_WIDTH-1:0]   THR_RESET   = 15'd3277;
    localparam logic [LIMIT_WIDTH-1:0] SHORT_RESET = 16'd100;
    localparam logic [LIMIT_WIDTH-1:0] LONG_RESET  = 16'd230;

    typedef enum logic [1:0] {
        CLS_SHORT  = 2'd0,
        CLS_MEDIUM = 2'd1,
        CLS_LONG   = 2'd2
    } cls_t;

    typedef struct packed {
        logic [THR_WIDTH-1:0]   level_threshold;
        logic [LIMIT_WIDTH-1:0] short_limit;
        logic [LIMIT_WIDTH-1:0] long_limit;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

[rtl/tpwd_front.sv]
module tpwd_front (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  tpwd_pkg::cfg_t                          cfg,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic signed [tpwd_pkg::SAMPLE_WIDTH-1:0] sample,
    input  logic                                    last_sample,
    input  tpwd_pkg::fifo_stat_t                    fifo_stat,
    output logic                                    push,
    output tpwd_pkg::cls_t                          push_cls
);

    logic                                   prev_level_reg;
    logic [tpwd_pkg::COUNT_WIDTH-1:0]       run_length_reg;
    logic                                   accept;
    logic                                   level;
    logic                                   run_end;
    logic signed [tpwd_pkg::LVL_WIDTH-1:0]  sample_ext;
    logic signed [tpwd_pkg::LVL_WIDTH-1:0]  neg_thr;
    logic [tpwd_pkg::CMP_WIDTH-1:0]         run_ext;

    assign s_tready   = !fifo_stat.full;
    assign accept     = s_tvalid && s_tready;
    assign sample_ext = tpwd_pkg::LVL_WIDTH'(sample);
    assign neg_thr    = tpwd_pkg::LVL_WIDTH'(0)
                      - $signed(tpwd_pkg::LVL_WIDTH'(cfg.level_threshold));
    assign level      = (sample_ext < neg_thr);
    assign run_end    = (level != prev_level_reg) || last_sample;
    assign run_ext    = tpwd_pkg::CMP_WIDTH'(run_length_reg);
    assign push       = accept && run_end && !prev_level_reg;

    always_comb begin
        if (run_ext < tpwd_pkg::CMP_WIDTH'(cfg.short_limit)) begin
            push_cls = tpwd_pkg::CLS_SHORT;
        end else if (run_ext < tpwd_pkg::CMP_WIDTH'(cfg.long_limit)) begin
            push_cls = tpwd_pkg::CLS_MEDIUM;
        end else begin
            push_cls = tpwd_pkg::CLS_LONG;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg <= 1'b0;
            run_length_reg <= '0;
        end else if (accept) begin
            prev_level_reg <= level;
            if (run_end) begin
                run_length_reg <= '0;
            end else if (run_length_reg != {tpwd_pkg::COUNT_WIDTH{1'b1}}) begin
                run_length_reg <= run_length_reg + 1'b1;
            end
        end
    end

endmodule

[rtl/tpwd_fifo.sv]
module tpwd_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  tpwd_pkg::cls_t       push_cls,
    input  logic                 pop,
    output tpwd_pkg::cls_t       pop_cls,
    output tpwd_pkg::fifo_stat_t stat
);

    tpwd_pkg::cls_t                 mem_reg [tpwd_pkg::FIFO_DEPTH];
    logic [tpwd_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [tpwd_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [tpwd_pkg::FIFO_AW:0]     count_reg;
    logic                           do_push;
    logic                           do_pop;

    assign stat.full  = (count_reg == (tpwd_pkg::FIFO_AW+1)'(tpwd_pkg::FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_cls    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[rtl/tpwd_back.sv]
module tpwd_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  tpwd_pkg::fifo_stat_t               fifo_stat,
    input  tpwd_pkg::cls_t                     pop_cls,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tpwd_pkg::BYTE_WIDTH-1:0]    data_byte,
    output logic                               is_sync
);

    logic [tpwd_pkg::BYTE_WIDTH-1:0] shift_byte_reg;
    logic [tpwd_pkg::BYTE_WIDTH-1:0] shift_byte_next;
    logic                            half_pulse_reg;
    logic                            half_pulse_next;
    logic                            hunting_reg;
    logic                            hunting_next;
    logic                            m_tvalid_reg;
    logic [tpwd_pkg::BYTE_WIDTH-1:0] data_byte_reg;
    logic                            is_sync_reg;
    logic                            emit;
    logic                            emit_sync;

    assign pop       = !fifo_stat.empty && (!m_tvalid_reg || m_tready);
    assign m_tvalid  = m_tvalid_reg;
    assign data_byte = data_byte_reg;
    assign is_sync   = is_sync_reg;

    always_comb begin
        shift_byte_next = shift_byte_reg;
        half_pulse_next = half_pulse_reg;
        hunting_next    = hunting_reg;
        emit            = 1'b0;
        emit_sync       = 1'b0;
        unique case (pop_cls)
            tpwd_pkg::CLS_SHORT: begin
                if (half_pulse_reg) begin
                    shift_byte_next = {1'b1, shift_byte_reg[tpwd_pkg::BYTE_WIDTH-1:1]};
                end
                half_pulse_next = !half_pulse_reg;
            end
            tpwd_pkg::CLS_MEDIUM: begin
                shift_byte_next = {1'b0, shift_byte_reg[tpwd_pkg::BYTE_WIDTH-1:1]};
            end
            default: begin
                shift_byte_next = {half_pulse_reg, shift_byte_reg[tpwd_pkg::BYTE_WIDTH-1:1]};
                half_pulse_next = 1'b0;
                emit            = !hunting_reg;
            end
        endcase
        if (hunting_reg && shift_byte_next == tpwd_pkg::SYNC_BYTE) begin
            hunting_next = 1'b0;
            emit         = 1'b1;
            emit_sync    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_byte_reg <= '0;
            half_pulse_reg <= 1'b0;
            hunting_reg    <= 1'b1;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (pop) begin
                shift_byte_reg <= shift_byte_next;
                half_pulse_reg <= half_pulse_next;
                hunting_reg    <= hunting_next;
                m_tvalid_reg   <= emit;
                if (emit) begin
                    data_byte_reg <= shift_byte_next;
                    is_sync_reg   <= emit_sync;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

[rtl/tape_pulse_width_byte_decoder.sv]
// Tape pulse-width byte decoder.
// s_ channel: one sample per beat, tdata = sample (signed), tlast = last sample
// of the recording; tlast ends the current run at that sample.
// m_ channel: one decoded byte per beat, tdata = byte, tuser[0] = sync marker
// (set only on the A5h byte that ends the sync hunt).
// cfg channel: cfg_index selects level_threshold (0), short_limit (1) or
// long_limit (2); cfg_ready is always high. Write only while the block is idle.
// Throughput: one sample per cycle while s_tready is high. A front stage
// measures runs and classifies each finished low run in the accept cycle;
// a 4-entry queue feeds a back stage that shifts bits and loads the output
// register, which takes a byte after its class leaves the queue. While
// m_tready is low and a byte is valid, the output register holds it, the
// back stage stops, the queue fills and then s_tready drops.
// Reset (aresetn low, synchronous) restores register defaults, clears the run
// counter, shift byte and queue, and restarts the sync hunt.
module tape_pulse_width_byte_decoder (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [tpwd_pkg::S_TDATA_WIDTH-1:0]     s_tdata,   // sample
    input  logic                                   s_tlast,   // last_sample
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [tpwd_pkg::M_TDATA_WIDTH-1:0]     m_tdata,   // data_byte
    output logic                                   m_tuser,   // is_sync
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [tpwd_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  logic [tpwd_pkg::LIMIT_WIDTH-1:0]       cfg_data
);

    tpwd_pkg::cfg_t       cfg_reg;
    tpwd_pkg::fifo_stat_t fifo_stat;
    tpwd_pkg::cls_t       push_cls;
    tpwd_pkg::cls_t       pop_cls;
    logic                 push;
    logic                 pop;
    logic signed [tpwd_pkg::SAMPLE_WIDTH-1:0] sample;

    assign cfg_ready = 1'b1;
    assign sample    = $signed(s_tdata[tpwd_pkg::SAMPLE_WIDTH-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.level_threshold <= tpwd_pkg::THR_RESET;
            cfg_reg.short_limit     <= tpwd_pkg::SHORT_RESET;
            cfg_reg.long_limit      <= tpwd_pkg::LONG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tpwd_pkg::REG_LEVEL_THRESHOLD:
                    cfg_reg.level_threshold <= cfg_data[tpwd_pkg::THR_WIDTH-1:0];
                tpwd_pkg::REG_SHORT_LIMIT: cfg_reg.short_limit <= cfg_data;
                tpwd_pkg::REG_LONG_LIMIT:  cfg_reg.long_limit  <= cfg_data;
                default: ;
            endcase
        end
    end

    tpwd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .sample      (sample),
        .last_sample (s_tlast),
        .fifo_stat   (fifo_stat),
        .push        (push),
        .push_cls    (push_cls)
    );

    tpwd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cls (push_cls),
        .pop      (pop),
        .pop_cls  (pop_cls),
        .stat     (fifo_stat)
    );

    tpwd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fifo_stat (fifo_stat),
        .pop_cls   (pop_cls),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .data_byte (m_tdata),
        .is_sync   (m_tuser)
    );

endmodule

[rtl/tpwd_checker.sv]
module tpwd_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [tpwd_pkg::M_TDATA_WIDTH-1:0] m_tdata,
    input logic                               m_tuser
);

    logic sync_seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_seen_reg <= 1'b0;
        end else if (m_tvalid && m_tready && m_tuser) begin
            sync_seen_reg <= 1'b1;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    a_sync_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == tpwd_pkg::SYNC_BYTE)
        else $error("sync beat carries a byte other than A5h");

    a_sync_once: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !sync_seen_reg)
        else $error("second sync beat");

    a_data_after_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> sync_seen_reg)
        else $error("data beat before sync");

    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind tape_pulse_width_byte_decoder tpwd_checker u_tpwd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 180;

    typedef logic [tpwd_pkg::CFG_IDX_WIDTH-1:0] cfg_idx_t;

    typedef struct packed {
        logic [tpwd_pkg::BYTE_WIDTH-1:0] value;
        logic                            sync_flag;
    } tape_byte_t;

    typedef enum logic [1:0] {
        ROW_RUN,
        ROW_BYTE,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t                                kind;
        logic signed [tpwd_pkg::SAMPLE_WIDTH-1:0] smp;
        logic                                     lst;
        logic [31:0]                              reps;
        cfg_idx_t                                 idx;
        logic [tpwd_pkg::LIMIT_WIDTH-1:0]         val;
        logic                                     pinned;
        tape_byte_t                               want;
    } plan_row_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_BLOCKS
    } rx_mode_t;

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [tpwd_pkg::S_TDATA_WIDTH-1:0] s_tdata   = '0;
    logic                               s_tlast   = 1'b0;
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [tpwd_pkg::M_TDATA_WIDTH-1:0] m_tdata;
    logic                               m_tuser;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    cfg_idx_t                           cfg_index = '0;
    logic [tpwd_pkg::LIMIT_WIDTH-1:0]   cfg_data  = '0;

    // decoder state mirror
    logic [tpwd_pkg::THR_WIDTH-1:0]   thr_q     = tpwd_pkg::THR_RESET;
    logic [tpwd_pkg::LIMIT_WIDTH-1:0] short_q   = tpwd_pkg::SHORT_RESET;
    logic [tpwd_pkg::LIMIT_WIDTH-1:0] long_q    = tpwd_pkg::LONG_RESET;
    logic                             prev_lvl  = 1'b0;
    logic [tpwd_pkg::COUNT_WIDTH-1:0] run_len   = '0;
    logic                             half_bit  = 1'b0;
    logic [tpwd_pkg::BYTE_WIDTH-1:0]  shift_reg = '0;
    logic                             hunting   = 1'b1;

    tape_byte_t pending_bytes[$];
    plan_row_t  plan[$];
    bit         pinned_on   = 1'b0;
    tape_byte_t pinned_want = '0;

    int       cycle_count = 0;
    int       err_count   = 0;
    int       n_samples   = 0;
    int       n_bytes     = 0;
    int       n_sync      = 0;
    int       n_writes    = 0;
    int       burst_left  = 0;
    int       rx_tick     = 0;
    rx_mode_t rx_mode     = RX_OPEN;

    tape_pulse_width_byte_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // sample
        .s_tlast   (s_tlast),   // last_sample
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // data_byte
        .m_tuser   (m_tuser),   // is_sync
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tape_pulse_width_byte_decoder test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[cycle %0d] %s", cycle_count, msg);
        err_count++;
    endtask

    function automatic bit decode_sample(
        input logic signed [tpwd_pkg::SAMPLE_WIDTH-1:0] smp,
        input logic lst, output tape_byte_t res);
        int sval;
        int tval;
        bit lvl;
        bit hit;
        sval = smp;
        tval = thr_q;
        lvl  = (sval < -tval);
        hit  = 1'b0;
        res  = '0;
        if (lvl == prev_lvl && !lst) begin
            if (run_len != '1)
                run_len = run_len + 1'b1;
        end else begin
            if (!prev_lvl) begin
                if (run_len < short_q) begin
                    if (half_bit)
                        shift_reg = {1'b1, shift_reg[tpwd_pkg::BYTE_WIDTH-1:1]};
                    half_bit = ~half_bit;
                end else if (run_len < long_q) begin
                    shift_reg = {1'b0, shift_reg[tpwd_pkg::BYTE_WIDTH-1:1]};
                end else begin
                    shift_reg = {half_bit, shift_reg[tpwd_pkg::BYTE_WIDTH-1:1]};
                    half_bit  = 1'b0;
                    if (!hunting) begin
                        res = {shift_reg, 1'b0};
                        hit = 1'b1;
                    end
                end
                if (hunting && shift_reg == tpwd_pkg::SYNC_BYTE) begin
                    hunting = 1'b0;
                    res     = {shift_reg, 1'b1};
                    hit     = 1'b1;
                end
            end
            run_len = '0;
        end
        prev_lvl = lvl;
        return hit;
    endfunction

    task automatic send_sample(input logic signed [tpwd_pkg::SAMPLE_WIDTH-1:0] smp,
                               input logic lst);
        tape_byte_t got;
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 24);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        n_samples++;
        if (decode_sample(smp, lst, got))
            pending_bytes = {pending_bytes, (pinned_on ? pinned_want : got)};
    endtask

    function automatic logic signed [tpwd_pkg::SAMPLE_WIDTH-1:0] level_sample(
        input bit lvl);
        int t;
        int v;
        t = thr_q;
        if (lvl)
            v = -32768 + int'($urandom_range(0, 32767 - t));
        else
            v = -t + int'($urandom_range(0, 32767 + t));
        return v[tpwd_pkg::SAMPLE_WIDTH-1:0];
    endfunction

    // run_length reached at the end of a low run, drawn from the wanted class
    function automatic int pick_count(input tpwd_pkg::cls_t cls);
        int lo;
        if (cls == tpwd_pkg::CLS_SHORT && short_q != 0)
            return $urandom_range(0, int'(short_q) - 1);
        if (cls != tpwd_pkg::CLS_LONG && long_q > short_q)
            return $urandom_range(int'(short_q), int'(long_q) - 1);
        lo = (long_q > short_q) ? int'(long_q) : int'(short_q);
        return lo + $urandom_range(0, 3);
    endfunction

    task automatic send_level_run(input bit lvl, input int n);
        repeat (n) send_sample(level_sample(lvl), 1'b0);
    endtask

    task automatic send_pulse(input tpwd_pkg::cls_t cls);
        send_level_run(1'b0, pick_count(cls) + 1);
        send_level_run(1'b1, $urandom_range(1, 3));
    endtask

    // LSB first; the last bit rides on the byte-ending long run
    task automatic send_tape_byte(input logic [tpwd_pkg::BYTE_WIDTH-1:0] v,
                                  input int nbits);
        int i;
        for (i = 0; i < nbits - 1; i++) begin
            if (v[i]) begin
                send_pulse(tpwd_pkg::CLS_SHORT);
                send_pulse(tpwd_pkg::CLS_SHORT);
            end else begin
                send_pulse(tpwd_pkg::CLS_MEDIUM);
            end
        end
        if (v[nbits-1])
            send_pulse(tpwd_pkg::CLS_SHORT);
        send_pulse(tpwd_pkg::CLS_LONG);
    endtask

    task automatic wait_quiet();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx,
                             input logic [tpwd_pkg::LIMIT_WIDTH-1:0] val);
        wait_quiet();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            tpwd_pkg::REG_LEVEL_THRESHOLD: thr_q   = val[tpwd_pkg::THR_WIDTH-1:0];
            tpwd_pkg::REG_SHORT_LIMIT:     short_q = val;
            tpwd_pkg::REG_LONG_LIMIT:      long_q  = val;
            default: ;
        endcase
        n_writes++;
        @(negedge aclk) cfg_valid <= 1'b0;
    endtask

    function automatic void add_run(input int smp, input bit lst, input int reps);
        plan_row_t r;
        r      = '0;
        r.kind = ROW_RUN;
        r.smp  = smp[tpwd_pkg::SAMPLE_WIDTH-1:0];
        r.lst  = lst;
        r.reps = reps;
        plan   = {plan, r};
    endfunction

    function automatic void add_byte(input logic [tpwd_pkg::BYTE_WIDTH-1:0] v,
                                     input bit pin, input logic sync_flag);
        plan_row_t r;
        r        = '0;
        r.kind   = ROW_BYTE;
        r.val    = {8'h00, v};
        r.pinned = pin;
        r.want   = {v, sync_flag};
        plan     = {plan, r};
    endfunction

    function automatic void add_cfg(input cfg_idx_t idx, input int v);
        plan_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.val  = v[tpwd_pkg::LIMIT_WIDTH-1:0];
        plan   = {plan, r};
    endfunction

    always @(negedge aclk) begin
        rx_tick++;
        if (rx_tick % 64 == 0)
            rx_mode = rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= $urandom_range(0, 1);
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= ((rx_tick % 16) < 5);
        endcase
    end

    always @(posedge aclk) begin : check_bytes
        tape_byte_t head;
        if (aresetn && m_tvalid && m_tready) begin
            n_bytes++;
            if (m_tuser)
                n_sync++;
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected beat: byte %02h sync %0b",
                                          m_tdata, m_tuser));
            end else begin
                head = pending_bytes.pop_front();
                if (m_tdata !== head.value)
                    report_mismatch($sformatf("data_byte %02h, want %02h",
                                              m_tdata, head.value));
                if (m_tuser !== head.sync_flag)
                    report_mismatch($sformatf("is_sync %0b, want %0b on byte %02h",
                                              m_tuser, head.sync_flag, head.value));
            end
        end
    end

    initial begin : stimulus
        int start_samples;
        int phase_end;
        int act;
        int shrt;
        int lng;

        // low run right at the default short limit decodes as a zero bit
        add_run(0, 1'b0, 100);
        add_run(-32768, 1'b0, 2);
        // sync from a known empty shift byte, then plain bytes
        add_cfg(tpwd_pkg::REG_SHORT_LIMIT, 2);
        add_cfg(tpwd_pkg::REG_LONG_LIMIT, 4);
        add_byte(8'hA5, 1'b1, 1'b1);
        add_byte(8'h00, 1'b1, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b0);
        // level just past and at the threshold, last flag on each level
        add_run(-3278, 1'b0, 3);
        add_run(-3277, 1'b0, 3);
        add_run(32767, 1'b1, 1);
        add_run(-32768, 1'b1, 1);
        add_cfg(tpwd_pkg::REG_LEVEL_THRESHOLD, 0);
        add_run(-1, 1'b0, 2);
        add_run(0, 1'b0, 2);
        add_cfg(tpwd_pkg::REG_LEVEL_THRESHOLD, 32767);
        add_run(-32767, 1'b0, 3);
        add_run(-32768, 1'b0, 2);
        // no short class
        add_cfg(tpwd_pkg::REG_SHORT_LIMIT, 0);
        add_cfg(tpwd_pkg::REG_LONG_LIMIT, 3);
        add_byte(8'h3C, 1'b0, 1'b0);
        // long limit below short limit: no medium class
        add_cfg(tpwd_pkg::REG_SHORT_LIMIT, 3);
        add_cfg(tpwd_pkg::REG_LONG_LIMIT, 1);
        add_byte(8'hC3, 1'b0, 1'b0);

        repeat (9) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        foreach (plan[i]) begin
            pinned_on   = plan[i].pinned;
            pinned_want = plan[i].want;
            case (plan[i].kind)
                ROW_RUN:  repeat (plan[i].reps) send_sample(plan[i].smp, plan[i].lst);
                ROW_BYTE: send_tape_byte(plan[i].val[tpwd_pkg::BYTE_WIDTH-1:0], 8);
                default:  write_reg(plan[i].idx, plan[i].val);
            endcase
        end
        pinned_on = 1'b0;

        start_samples = n_samples;
        while (n_samples - start_samples < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       write_reg(tpwd_pkg::REG_LEVEL_THRESHOLD, 0);
                1:       write_reg(tpwd_pkg::REG_LEVEL_THRESHOLD, 32767);
                default: write_reg(tpwd_pkg::REG_LEVEL_THRESHOLD,
                                   $urandom_range(0, 32767));
            endcase
            if ($urandom_range(0, 7) == 0)
                shrt = 0;
            else if ($urandom_range(0, 5) == 0)
                shrt = $urandom_range(8, 14);
            else
                shrt = $urandom_range(1, 6);
            if ($urandom_range(0, 4) == 0)
                lng = $urandom_range(0, shrt);
            else
                lng = shrt + $urandom_range(1, 6);
            write_reg(tpwd_pkg::REG_SHORT_LIMIT, shrt);
            write_reg(tpwd_pkg::REG_LONG_LIMIT, lng);

            phase_end = n_samples + $urandom_range(50, 110);
            while (n_samples < phase_end) begin
                act = $urandom_range(0, 99);
                if (act < 75)
                    send_tape_byte($urandom_range(0, 255), 8);
                else if (act < 87)
                    send_tape_byte($urandom_range(0, 255), $urandom_range(1, 7));
                else
                    repeat ($urandom_range(1, 12))
                        send_sample(16'($urandom), ($urandom_range(0, 5) == 0));
            end
        end

        wait_quiet();

        $display("covered %0d samples, %0d decoded bytes (%0d sync)",
                 n_samples, n_bytes, n_sync);
        $display("%0d register writes: threshold and limit extremes, random limits",
                 n_writes);
        if (err_count == 0) begin
            $display("tape_pulse_width_byte_decoder test passed");
        end else begin
            $display("%0d mismatches", err_count);
            $display("tape_pulse_width_byte_decoder test failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/tpwd_pkg.sv
rtl/tpwd_front.sv
rtl/tpwd_fifo.sv
rtl/tpwd_back.sv
rtl/tape_pulse_width_byte_decoder.sv
rtl/tpwd_checker.sv
tb/testbench.sv
